>>> design/plac_pkg.sv
// Shared types, constants and helper functions for the process load accounting block.
package plac_pkg;

  localparam int CNT_W     = 7;
  localparam int MEM_W     = 28;
  localparam int LOAD_W    = 16;
  localparam int SIZE_W    = 20;
  localparam int UAREA_W   = 16;
  localparam int SLEEP_W   = 7;
  localparam int STATE_W   = 3;
  localparam int AMT_W     = 22;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;
  localparam int NUM_LOADS = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;
  localparam logic [MEM_W-1:0] MEM_MAX = 28'hFFFFFFF;

  // input action codes
  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_EOP    = 1'b1;

  // process state codes
  localparam logic [STATE_W-1:0] ST_EMPTY = 3'd0;
  localparam logic [STATE_W-1:0] ST_SLEEP = 3'd1;
  localparam logic [STATE_W-1:0] ST_STOP  = 3'd2;
  localparam logic [STATE_W-1:0] ST_RUN   = 3'd3;
  localparam logic [STATE_W-1:0] ST_IDLE  = 3'd4;
  localparam logic [STATE_W-1:0] ST_ZOMB  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLEEP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_AREA = 1'b1;

  localparam logic [SLEEP_W-1:0] MAX_SLEEP_RST = 7'd20;
  localparam logic [UAREA_W-1:0] USER_AREA_RST = 16'd3072;

  // decay factors over 256: short, medium, long
  localparam logic [7:0] DECAY_COEF [NUM_LOADS] = '{8'o353, 8'o373, 8'o376};

  // per-beat increments produced by the record decoder
  typedef struct packed {
    logic             eop;
    logic             run;
    logic             rq;
    logic             dw;
    logic             sl;
    logic             sw;
    logic             vm;
    logic             avm;
    logic             rm;
    logic             arm;
    logic [AMT_W-1:0] amount;
  } incr_t;

  typedef struct packed {
    logic        [CNT_W-1:0]  run_count;
    logic signed [LOAD_W-1:0] load_short;
    logic signed [LOAD_W-1:0] load_medium;
    logic signed [LOAD_W-1:0] load_long;
    logic        [CNT_W-1:0]  run_queue_count;
    logic        [CNT_W-1:0]  disk_wait_count;
    logic        [CNT_W-1:0]  sleeper_count;
    logic        [CNT_W-1:0]  swapped_count;
    logic        [MEM_W-1:0]  virtual_total;
    logic        [MEM_W-1:0]  active_virtual_total;
    logic        [MEM_W-1:0]  resident_total;
    logic        [MEM_W-1:0]  active_resident_total;
  } result_t;

  function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] cnt, input logic en);
    sat_bump = (en && cnt != CNT_MAX) ? cnt + 7'd1 : cnt;
  endfunction

  function automatic logic [MEM_W-1:0] sat_add(input logic [MEM_W-1:0] tot,
                                               input logic [AMT_W-1:0] amt,
                                               input logic en);
    logic [MEM_W:0] s;
    s = {1'b0, tot} + {{(MEM_W+1-AMT_W){1'b0}}, amt};
    if (!en)
      sat_add = tot;
    else if (s > {1'b0, MEM_MAX})
      sat_add = MEM_MAX;
    else
      sat_add = s[MEM_W-1:0];
  endfunction

endpackage

>>> design/plac_in_if.sv
// Input channel: one process record or end-of-pass beat.
interface plac_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [plac_pkg::STATE_W-1:0]        proc_state;
  logic                                is_system;
  logic                                is_loaded;
  logic                                is_interruptible;
  logic [plac_pkg::SLEEP_W-1:0]        sleep_time;
  logic [plac_pkg::SIZE_W-1:0]         data_size;
  logic [plac_pkg::SIZE_W-1:0]         stack_size;

  modport source (output valid, action, proc_state, is_system, is_loaded, is_interruptible,
                  sleep_time, data_size, stack_size, input ready);
  modport sink   (input valid, action, proc_state, is_system, is_loaded, is_interruptible,
                  sleep_time, data_size, stack_size, output ready);
endinterface

>>> design/plac_out_if.sv
// Result channel: totals and load averages for one pass.
interface plac_out_if;
  logic                                valid;
  logic                                ready;
  logic        [plac_pkg::CNT_W-1:0]   run_count;
  logic signed [plac_pkg::LOAD_W-1:0]  load_short;
  logic signed [plac_pkg::LOAD_W-1:0]  load_medium;
  logic signed [plac_pkg::LOAD_W-1:0]  load_long;
  logic        [plac_pkg::CNT_W-1:0]   run_queue_count;
  logic        [plac_pkg::CNT_W-1:0]   disk_wait_count;
  logic        [plac_pkg::CNT_W-1:0]   sleeper_count;
  logic        [plac_pkg::CNT_W-1:0]   swapped_count;
  logic        [plac_pkg::MEM_W-1:0]   virtual_total;
  logic        [plac_pkg::MEM_W-1:0]   active_virtual_total;
  logic        [plac_pkg::MEM_W-1:0]   resident_total;
  logic        [plac_pkg::MEM_W-1:0]   active_resident_total;

  modport source (output valid, run_count, load_short, load_medium, load_long,
                  run_queue_count, disk_wait_count, sleeper_count, swapped_count,
                  virtual_total, active_virtual_total, resident_total,
                  active_resident_total, input ready);
  modport sink   (input valid, run_count, load_short, load_medium, load_long,
                  run_queue_count, disk_wait_count, sleeper_count, swapped_count,
                  virtual_total, active_virtual_total, resident_total,
                  active_resident_total, output ready);
endinterface

>>> design/plac_decode.sv
// Record decoder: classifies one process record into counter and total increments.
module plac_decode (
  input  logic                          action,
  input  logic [plac_pkg::STATE_W-1:0]  proc_state,
  input  logic                          is_system,
  input  logic                          is_loaded,
  input  logic                          is_interruptible,
  input  logic [plac_pkg::SLEEP_W-1:0]  sleep_time,
  input  logic [plac_pkg::SIZE_W-1:0]   data_size,
  input  logic [plac_pkg::SIZE_W-1:0]   stack_size,
  input  logic [plac_pkg::SLEEP_W-1:0]  max_sleep_time,
  input  logic [plac_pkg::UAREA_W-1:0]  user_area_size,
  output plac_pkg::incr_t               incr
);

  logic live;
  logic recent;
  logic sleepish;
  logic running;
  logic active;

  always_comb begin
    live     = !is_system && proc_state != plac_pkg::ST_EMPTY && action == plac_pkg::ACT_RECORD;
    recent   = sleep_time < max_sleep_time;
    sleepish = proc_state == plac_pkg::ST_SLEEP || proc_state == plac_pkg::ST_STOP;
    running  = proc_state == plac_pkg::ST_RUN || proc_state == plac_pkg::ST_IDLE;
    active   = running || (sleepish && recent);

    incr        = '0;
    incr.eop    = action == plac_pkg::ACT_EOP;
    incr.amount = {2'b00, data_size} + {2'b00, stack_size}
                + {{(plac_pkg::AMT_W-plac_pkg::UAREA_W){1'b0}}, user_area_size};
    if (live) begin
      // undefined state codes still count as non-zombie memory
      incr.vm  = proc_state != plac_pkg::ST_ZOMB;
      incr.rm  = proc_state != plac_pkg::ST_ZOMB && is_loaded;
      incr.avm = active;
      incr.arm = active && is_loaded;
      incr.run = running || (proc_state == plac_pkg::ST_SLEEP && !is_interruptible);
      incr.rq  = running && is_loaded;
      incr.dw  = sleepish && is_loaded && !is_interruptible;
      incr.sl  = sleepish && is_loaded && is_interruptible && recent;
      incr.sw  = (running && !is_loaded) || (sleepish && !is_loaded && recent);
    end
  end

endmodule

>>> design/plac_accum.sv
// Accumulator: saturating counters and totals, load average update and result register.
module plac_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  plac_pkg::incr_t   incr,
  input  logic              out_ready,
  output logic              out_valid,
  output plac_pkg::result_t result
);

  logic [plac_pkg::CNT_W-1:0]  run_r, run_nxt;
  logic [plac_pkg::CNT_W-1:0]  rq_r, rq_nxt, dw_r, dw_nxt, sl_r, sl_nxt, sw_r, sw_nxt;
  logic [plac_pkg::MEM_W-1:0]  vm_r, vm_nxt, avm_r, avm_nxt, rm_r, rm_nxt, arm_r, arm_nxt;
  logic [plac_pkg::LOAD_W-1:0] load_r [plac_pkg::NUM_LOADS];
  logic [plac_pkg::LOAD_W-1:0] load_nxt [plac_pkg::NUM_LOADS];
  logic [plac_pkg::LOAD_W-1:0] load_new [plac_pkg::NUM_LOADS];
  logic                        out_valid_r, out_valid_nxt;
  plac_pkg::result_t           result_r, result_nxt;

  logic signed [17:0] diff [plac_pkg::NUM_LOADS];
  logic signed [26:0] prod [plac_pkg::NUM_LOADS];
  logic signed [26:0] acc  [plac_pkg::NUM_LOADS];

  // avg' = (c*(avg - n*256) + n*65536) >> 8, only bits [23:8] survive
  always_comb begin
    for (int i = 0; i < plac_pkg::NUM_LOADS; i++) begin
      diff[i]     = {{2{load_r[i][plac_pkg::LOAD_W-1]}}, load_r[i]}
                  - $signed({3'b000, run_r, 8'h00});
      prod[i]     = diff[i] * $signed({1'b0, plac_pkg::DECAY_COEF[i]});
      acc[i]      = prod[i] + $signed({4'b0000, run_r, 16'h0000});
      load_new[i] = acc[i][23:8];
    end
  end

  always_comb begin
    run_nxt       = run_r;
    rq_nxt        = rq_r;
    dw_nxt        = dw_r;
    sl_nxt        = sl_r;
    sw_nxt        = sw_r;
    vm_nxt        = vm_r;
    avm_nxt       = avm_r;
    rm_nxt        = rm_r;
    arm_nxt       = arm_r;
    load_nxt      = load_r;
    result_nxt    = result_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (fire) begin
      if (incr.eop) begin
        out_valid_nxt                    = 1'b1;
        load_nxt                         = load_new;
        result_nxt.run_count             = run_r;
        result_nxt.load_short            = load_new[0];
        result_nxt.load_medium           = load_new[1];
        result_nxt.load_long             = load_new[2];
        result_nxt.run_queue_count       = rq_r;
        result_nxt.disk_wait_count       = dw_r;
        result_nxt.sleeper_count         = sl_r;
        result_nxt.swapped_count         = sw_r;
        result_nxt.virtual_total         = vm_r;
        result_nxt.active_virtual_total  = avm_r;
        result_nxt.resident_total        = rm_r;
        result_nxt.active_resident_total = arm_r;
        run_nxt = '0;
        rq_nxt  = '0;
        dw_nxt  = '0;
        sl_nxt  = '0;
        sw_nxt  = '0;
        vm_nxt  = '0;
        avm_nxt = '0;
        rm_nxt  = '0;
        arm_nxt = '0;
      end else begin
        run_nxt = plac_pkg::sat_bump(run_r, incr.run);
        rq_nxt  = plac_pkg::sat_bump(rq_r, incr.rq);
        dw_nxt  = plac_pkg::sat_bump(dw_r, incr.dw);
        sl_nxt  = plac_pkg::sat_bump(sl_r, incr.sl);
        sw_nxt  = plac_pkg::sat_bump(sw_r, incr.sw);
        vm_nxt  = plac_pkg::sat_add(vm_r, incr.amount, incr.vm);
        avm_nxt = plac_pkg::sat_add(avm_r, incr.amount, incr.avm);
        rm_nxt  = plac_pkg::sat_add(rm_r, incr.amount, incr.rm);
        arm_nxt = plac_pkg::sat_add(arm_r, incr.amount, incr.arm);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= '0;
      rq_r        <= '0;
      dw_r        <= '0;
      sl_r        <= '0;
      sw_r        <= '0;
      vm_r        <= '0;
      avm_r       <= '0;
      rm_r        <= '0;
      arm_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < plac_pkg::NUM_LOADS; i++) begin
        load_r[i] <= '0;
      end
    end else begin
      run_r       <= run_nxt;
      rq_r        <= rq_nxt;
      dw_r        <= dw_nxt;
      sl_r        <= sl_nxt;
      sw_r        <= sw_nxt;
      vm_r        <= vm_nxt;
      avm_r       <= avm_nxt;
      rm_r        <= rm_nxt;
      arm_r       <= arm_nxt;
      out_valid_r <= out_valid_nxt;
      load_r      <= load_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

>>> design/process_load_accounting_unit.sv
// Process load accounting unit: accepts one process-table record or end-of-pass beat per
// cycle while no end-of-pass beat is held. A record is decoded as it arrives and lands in
// an input register; the next cycle it updates the saturating class counters and memory
// totals. An end-of-pass beat updates the three 8.8 load averages from the run count,
// loads the result register and clears the counters; its result beat is then offered.
// Records keep flowing while a result waits on the output; only a second end-of-pass beat
// holds in the input register until the earlier result is taken. Configuration writes
// take effect on beats accepted after the write.
module process_load_accounting_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  plac_in_if.sink                        in_chan,
  plac_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [plac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [plac_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  logic [plac_pkg::SLEEP_W-1:0] max_sleep_r, max_sleep_nxt;
  logic [plac_pkg::UAREA_W-1:0] user_area_r, user_area_nxt;
  logic                         s1_valid_r, s1_valid_nxt;
  plac_pkg::incr_t              s1_incr_r, s1_incr_nxt;
  plac_pkg::incr_t              dec_incr;
  logic                         s1_go;
  logic                         in_take;
  logic                         out_valid;
  plac_pkg::result_t            result;

  plac_decode u_decode (
    .action           (in_chan.action),
    .proc_state       (in_chan.proc_state),
    .is_system        (in_chan.is_system),
    .is_loaded        (in_chan.is_loaded),
    .is_interruptible (in_chan.is_interruptible),
    .sleep_time       (in_chan.sleep_time),
    .data_size        (in_chan.data_size),
    .stack_size       (in_chan.stack_size),
    .max_sleep_time   (max_sleep_r),
    .user_area_size   (user_area_r),
    .incr             (dec_incr)
  );

  // an end-of-pass beat may only move when the result register is free or emptying
  assign s1_go          = !s1_incr_r.eop || !out_valid || out_chan.ready;
  assign in_chan.ready  = !s1_valid_r || s1_go;
  assign in_take        = in_chan.valid && in_chan.ready;

  always_comb begin
    max_sleep_nxt = max_sleep_r;
    user_area_nxt = user_area_r;
    if (cfg_we) begin
      unique case (cfg_index)
        plac_pkg::CFG_MAX_SLEEP: max_sleep_nxt = cfg_wdata[plac_pkg::SLEEP_W-1:0];
        plac_pkg::CFG_USER_AREA: user_area_nxt = cfg_wdata[plac_pkg::UAREA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_incr_nxt  = in_take ? dec_incr : s1_incr_r;
    s1_valid_nxt = in_take || (s1_valid_r && !s1_go);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_sleep_r <= plac_pkg::MAX_SLEEP_RST;
      user_area_r <= plac_pkg::USER_AREA_RST;
      s1_valid_r  <= 1'b0;
    end else begin
      max_sleep_r <= max_sleep_nxt;
      user_area_r <= user_area_nxt;
      s1_valid_r  <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_incr_r <= s1_incr_nxt;
  end

  plac_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_valid_r && s1_go),
    .incr      (s1_incr_r),
    .out_ready (out_chan.ready),
    .out_valid (out_valid),
    .result    (result)
  );

  assign out_chan.valid                 = out_valid;
  assign out_chan.run_count             = result.run_count;
  assign out_chan.load_short            = result.load_short;
  assign out_chan.load_medium           = result.load_medium;
  assign out_chan.load_long             = result.load_long;
  assign out_chan.run_queue_count       = result.run_queue_count;
  assign out_chan.disk_wait_count       = result.disk_wait_count;
  assign out_chan.sleeper_count         = result.sleeper_count;
  assign out_chan.swapped_count         = result.swapped_count;
  assign out_chan.virtual_total         = result.virtual_total;
  assign out_chan.active_virtual_total  = result.active_virtual_total;
  assign out_chan.resident_total        = result.resident_total;
  assign out_chan.active_resident_total = result.active_resident_total;

endmodule
